[sv/b64d_pkg.sv]
package b64d_pkg;

   localparam int MAX_MESSAGE_CHARS = 1024;
   localparam int CHAR_COUNT_W      = $clog2(MAX_MESSAGE_CHARS + 2);
   localparam int NOMINAL_COUNT_W   = 10;
   localparam int QUEUE_DEPTH       = 4;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_LENGTH   = 2'd1,
      STATUS_BAD_CHAR = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       last_char;
   } req_item_type;

   typedef struct packed {
      logic [7:0]                 byte_out;
      logic                       byte_valid;
      logic                       end_of_message;
      status_type                 status;
      logic [NOMINAL_COUNT_W-1:0] nominal_count;
   } rsp_item_type;

   // One decoded group, or one status-only result, on its way to the back end.
   typedef struct packed {
      logic [23:0]                triple;
      logic                       has_data;
      logic [1:0]                 num_results;
      logic                       eom;
      status_type                 status;
      logic [NOMINAL_COUNT_W-1:0] count;
   } group_entry_type;

endpackage

[sv/b64d_front.sv]
module b64d_front
   import b64d_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  req_item_type    req_item,
   output logic            req_ready,
   output logic            push_valid,
   output group_entry_type push_entry,
   input  logic            push_ready
);

   localparam int PROD_W = CHAR_COUNT_W + NOMINAL_COUNT_W;

   function automatic logic [6:0] map_char(input logic [7:0] c);
      logic [6:0] result;
      result = 7'h40;
      if (c >= "A" && c <= "Z") begin
         result = {1'b0, 6'(c - 8'("A"))};
      end else if (c >= "a" && c <= "z") begin
         result = {1'b0, 6'(c - 8'("a") + 8'd26)};
      end else if (c >= "0" && c <= "9") begin
         result = {1'b0, 6'(c - 8'("0") + 8'd52)};
      end else if (c == "+") begin
         result = 7'd62;
      end else if (c == "/") begin
         result = 7'd63;
      end else if (c == "=") begin
         result = 7'd0;
      end
      return result;
   endfunction

   logic [17:0]             accum_ff, accum_in;
   logic [1:0]              pos_ff, pos_in;
   logic                    pad_ff, pad_in;
   logic [CHAR_COUNT_W-1:0] count_ff, count_in;
   logic                    bad_ff, bad_in;

   logic                    accept;
   logic [CHAR_COUNT_W-1:0] count_next;
   logic [6:0]              mapped;
   logic                    is_pad;
   logic                    is_last;
   logic [CHAR_COUNT_W-1:0] quarter;
   logic [PROD_W-1:0]       prod;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;
   assign mapped    = map_char(req_item.char_in);
   assign is_pad    = (req_item.char_in == "=");
   assign is_last   = req_item.last_char;

   always_comb begin
      accum_in   = accum_ff;
      pos_in     = pos_ff;
      pad_in     = pad_ff;
      count_in   = count_ff;
      bad_in     = bad_ff;
      push_valid = 1'b0;
      push_entry = '0;
      if (count_ff <= CHAR_COUNT_W'(MAX_MESSAGE_CHARS)) begin
         count_next = count_ff + 1'b1;
      end else begin
         count_next = count_ff;
      end
      quarter = count_next >> 2;
      prod    = PROD_W'(quarter) + (PROD_W'(quarter) << 1);
      if (accept) begin
         count_in = count_next;
         if (count_next > CHAR_COUNT_W'(MAX_MESSAGE_CHARS)) begin
            if (is_last) begin
               push_valid             = 1'b1;
               push_entry.num_results = 2'd1;
               push_entry.eom         = 1'b1;
               push_entry.status      = STATUS_OVERFLOW;
               accum_in = '0;
               pos_in   = '0;
               pad_in   = 1'b0;
               count_in = '0;
               bad_in   = 1'b0;
            end
         end else begin
            bad_in = bad_ff | mapped[6];
            if (pos_ff != 2'd3) begin
               if (pos_ff == 2'd2) begin
                  pad_in = is_pad;
               end
               accum_in = {accum_ff[11:0], mapped[5:0]};
               pos_in   = pos_ff + 1'b1;
               if (is_last) begin
                  push_valid             = 1'b1;
                  push_entry.num_results = 2'd1;
                  push_entry.eom         = 1'b1;
                  push_entry.status      = STATUS_LENGTH;
                  accum_in = '0;
                  pos_in   = '0;
                  pad_in   = 1'b0;
                  count_in = '0;
                  bad_in   = 1'b0;
               end
            end else begin
               push_valid             = 1'b1;
               push_entry.triple      = {accum_ff, mapped[5:0]};
               push_entry.has_data    = 1'b1;
               push_entry.num_results = 2'd3 - {1'b0, is_last && is_pad}
                                             - {1'b0, is_last && pad_ff};
               push_entry.eom         = is_last;
               push_entry.status      = (is_last && bad_in) ? STATUS_BAD_CHAR : STATUS_OK;
               push_entry.count       = is_last ? prod[NOMINAL_COUNT_W-1:0] : '0;
               accum_in = '0;
               pos_in   = '0;
               pad_in   = 1'b0;
               if (is_last) begin
                  count_in = '0;
                  bad_in   = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         pos_ff   <= '0;
         pad_ff   <= 1'b0;
         count_ff <= '0;
         bad_ff   <= 1'b0;
      end else begin
         accum_ff <= accum_in;
         pos_ff   <= pos_in;
         pad_ff   <= pad_in;
         count_ff <= count_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

[sv/b64d_queue.sv]
module b64d_queue
   import b64d_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   input  group_entry_type push_entry,
   output logic            push_ready,
   output logic            pop_valid,
   output group_entry_type pop_entry,
   input  logic            pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   group_entry_type   slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (fill_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("Queue fill count exceeds its depth.");

   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (fill_ff == $past(fill_ff) + 1'b1))
      else $error("Queue fill count did not follow a push.");

endmodule

[sv/b64d_back.sv]
module b64d_back
   import b64d_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            entry_valid,
   input  group_entry_type entry,
   output logic            entry_pop,
   output logic            rsp_valid,
   output rsp_item_type    rsp_item,
   input  logic            rsp_ready
);

   group_entry_type cur_ff, cur_in;
   logic            cur_valid_ff, cur_valid_in;
   logic [1:0]      idx_ff, idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_item_type    rsp_item_ff, rsp_item_in;

   logic            fire;
   logic            final_piece;
   logic [7:0]      byte_sel;

   assign fire        = cur_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign final_piece = (idx_ff == cur_ff.num_results - 2'd1);
   assign entry_pop   = entry_valid && (!cur_valid_ff || (fire && final_piece));
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_item    = rsp_item_ff;

   always_comb begin
      unique case (idx_ff)
         2'd0:    byte_sel = cur_ff.triple[23:16];
         2'd1:    byte_sel = cur_ff.triple[15:8];
         default: byte_sel = cur_ff.triple[7:0];
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fire) begin
         rsp_valid_in               = 1'b1;
         rsp_item_in.byte_out       = cur_ff.has_data ? byte_sel : 8'd0;
         rsp_item_in.byte_valid     = cur_ff.has_data;
         rsp_item_in.end_of_message = final_piece && cur_ff.eom;
         rsp_item_in.status         = final_piece ? cur_ff.status : STATUS_OK;
         rsp_item_in.nominal_count  = final_piece ? cur_ff.count : '0;
         idx_in                     = idx_ff + 1'b1;
         if (final_piece) begin
            cur_valid_in = 1'b0;
         end
      end
      if (entry_pop) begin
         cur_in       = entry;
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_item_ff <= rsp_item_in;
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (cur_ff.num_results != 2'd0 && idx_ff < cur_ff.num_results))
      else $error("Back end index runs past the results of its entry.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_item_ff == $past(rsp_item_ff)))
      else $error("Stalled result item was overwritten.");

endmodule

[sv/base64_stream_decoder_core.sv]
// Streaming base64 decoder for the standard alphabet: one text character is
// taken per item, each group of four characters gives up to three bytes, and
// the last result of a message carries its status and nominal byte count. A
// new character is accepted every cycle; the front end classifies characters
// and packs complete groups into a four-entry queue, and the back end gives
// one result per cycle from the head of that queue, so the input stalls only
// when the result side stalls long enough to fill the queue.
module base64_stream_decoder_core
   import b64d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_item_type req_item,
   output logic         req_ready,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         rsp_ready
);

   logic            push_valid;
   group_entry_type push_entry;
   logic            push_ready;
   logic            head_valid;
   group_entry_type head_entry;
   logic            head_pop;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .req_ready  (req_ready),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (head_valid),
      .pop_entry  (head_entry),
      .pop        (head_pop)
   );

   b64d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (head_valid),
      .entry       (head_entry),
      .entry_pop   (head_pop),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .rsp_ready   (rsp_ready)
   );

endmodule

[verif/b64_decode_checker.sv]
module b64_decode_checker
   import b64d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_item_type rsp_item,
   output int           failures,
   output int           pending
);

   logic [17:0]  held_sextets;
   logic [1:0]   group_fill;
   logic         third_pad;
   int           chars_seen;
   logic         saw_bad;
   rsp_item_type expected_bytes[$];
   rsp_item_type want;

   function automatic void clear_message();
      held_sextets = '0;
      group_fill   = '0;
      third_pad    = 1'b0;
      chars_seen   = 0;
      saw_bad      = 1'b0;
   endfunction

   function automatic logic [5:0] sextet_of(input logic [7:0] c, output logic bad);
      bad = 1'b0;
      if (c >= "A" && c <= "Z") return 6'(c - 8'("A"));
      if (c >= "a" && c <= "z") return 6'(c - 8'("a") + 8'd26);
      if (c >= "0" && c <= "9") return 6'(c - 8'("0") + 8'd52);
      if (c == "+") return 6'd62;
      if (c == "/") return 6'd63;
      if (c == "=") return 6'd0;
      bad = 1'b1;
      return 6'd0;
   endfunction

   function automatic void add_result(input logic [7:0] data, input logic has_data,
                                      input logic eom, input status_type st,
                                      input logic [NOMINAL_COUNT_W-1:0] count);
      rsp_item_type r;
      r.byte_out       = data;
      r.byte_valid     = has_data;
      r.end_of_message = eom;
      r.status         = st;
      r.nominal_count  = count;
      expected_bytes.push_back(r);
   endfunction

   // Characters beyond the message limit are not decoded; the final one
   // of such a message reports the overflow.
   function automatic void predict_char(input req_item_type it);
      logic [5:0]                 s;
      logic                       bad;
      logic [23:0]                triple;
      int                         nbytes;
      logic                       fin;
      logic [NOMINAL_COUNT_W-1:0] count;
      if (chars_seen <= MAX_MESSAGE_CHARS) chars_seen++;
      if (chars_seen > MAX_MESSAGE_CHARS) begin
         if (it.last_char) begin
            add_result(8'h00, 1'b0, 1'b1, STATUS_OVERFLOW, '0);
            clear_message();
         end
         return;
      end
      s = sextet_of(it.char_in, bad);
      if (bad) saw_bad = 1'b1;
      if (group_fill < 2'd3) begin
         if (group_fill == 2'd2) third_pad = (it.char_in == "=");
         held_sextets = {held_sextets[11:0], s};
         group_fill++;
         if (it.last_char) begin
            add_result(8'h00, 1'b0, 1'b1, STATUS_LENGTH, '0);
            clear_message();
         end
         return;
      end
      triple = {held_sextets, s};
      nbytes = 3;
      if (it.last_char) begin
         if (it.char_in == "=") nbytes--;
         if (third_pad) nbytes--;
      end
      count = NOMINAL_COUNT_W'(chars_seen / 4 * 3);
      for (int i = 0; i < nbytes; i++) begin
         fin = it.last_char && (i + 1 == nbytes);
         add_result(triple[23 - 8 * i -: 8], 1'b1, fin,
                    (fin && saw_bad) ? STATUS_BAD_CHAR : STATUS_OK,
                    fin ? count : '0);
      end
      held_sextets = '0;
      group_fill   = '0;
      third_pad    = 1'b0;
      if (it.last_char) clear_message();
   endfunction

   function automatic void check_field(input string name, input int exp, input int got);
      if (exp != got) begin
         $error("%s expected %0d, got %0d", name, exp, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_message();
         expected_bytes.delete();
      end else begin
         if (req_valid && req_ready) predict_char(req_item);
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected item: byte_out %0d, status %0d",
                      rsp_item.byte_out, rsp_item.status);
               failures++;
            end else begin
               want = expected_bytes.pop_front();
               check_field("byte_out", int'(want.byte_out), int'(rsp_item.byte_out));
               check_field("byte_valid", int'(want.byte_valid),
                           int'(rsp_item.byte_valid));
               check_field("end_of_message", int'(want.end_of_message),
                           int'(rsp_item.end_of_message));
               check_field("status", int'(want.status), int'(rsp_item.status));
               check_field("nominal_count", int'(want.nominal_count),
                           int'(rsp_item.nominal_count));
            end
         end
      end
      pending = expected_bytes.size();
   end

endmodule

[verif/testbench.sv]
module testbench
   import b64d_pkg::*;
();

   localparam int STALL_LIMIT = 4000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_item;
   int           failures;
   int           pending;
   int           send_idle    = 29;
   int           recv_idle    = 69;
   int           chars_sent   = 0;
   int           quiet_cycles = 0;

   base64_stream_decoder_core dut (.*);

   b64_decode_checker monitor (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] alphabet_char(input int k);
      if (k < 26) return "A" + k[7:0];
      if (k < 52) return "a" + k[7:0] - 8'd26;
      if (k < 62) return "0" + k[7:0] - 8'd52;
      if (k == 62) return "+";
      return "/";
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_char(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{char_in: c, last_char: last};
      do @(posedge clock); while (!req_ready);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(input logic [7:0] text[$]);
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
   endtask

   // Mostly well-formed messages with optional padding, a few with a stray
   // byte, and some raw noise of one to nine bytes.
   task automatic random_message();
      logic [7:0] text[$];
      int         groups;
      int         pads;
      if ($urandom_range(99) < 80) begin
         groups = $urandom_range(1, 4);
         for (int i = 0; i < groups * 4; i++) text.push_back(alphabet_char($urandom_range(63)));
         pads = $urandom_range(2);
         if (pads >= 1) text[text.size() - 1] = "=";
         if (pads == 2 || $urandom_range(9) == 0) text[text.size() - 2] = "=";
         if ($urandom_range(9) == 0) text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
      end else begin
         repeat ($urandom_range(1, 9)) text.push_back(8'($urandom_range(255)));
      end
      send_message(text);
   endtask

   task automatic random_phase(input int count);
      int start;
      start = chars_sent;
      while (chars_sent - start < count) random_message();
   endtask

   initial begin
      logic [7:0] text[$];
      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      text = '{"A", "Z", "a", "z", "0", "9", "+", "/"};
      send_message(text);
      text = '{"T", "W", "E", "="};
      send_message(text);
      text = '{"T", "Q", "=", "="};
      send_message(text);
      text = '{"Q", "Q", "=", "A"};
      send_message(text);
      text = '{8'h00, "A", 8'hFF, "="};
      send_message(text);
      text = '{"A", 8'hFF};
      send_message(text);

      random_phase(30);
      send_idle = 69;
      recv_idle = 29;
      random_phase(30);
      send_idle = 0;
      recv_idle = 0;
      random_phase(30);
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
